// File: rtl/ppvm_pkg.sv
package ppvm_pkg;

    localparam int COORD_W   = 32;
    localparam int SCREEN_W  = 16;
    localparam int DIV_STEPS = 32;

    localparam logic signed [17:0] NEAR_SCALE = 18'sd100000;

    typedef enum logic [1:0] {
        MODE_OBLIQUE = 2'd0,
        MODE_PERSP   = 2'd1,
        MODE_SIDE    = 2'd2,
        MODE_TOP     = 2'd3
    } view_mode_t;

    typedef enum logic [2:0] {
        REG_VIEW_MODE    = 3'd0,
        REG_SCALE_X      = 3'd1,
        REG_SCALE_Y      = 3'd2,
        REG_OFFSET_X     = 3'd3,
        REG_OFFSET_Y     = 3'd4,
        REG_PROJ_A       = 3'd5,
        REG_PROJ_B       = 3'd6,
        REG_CENTRE_DEPTH = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        view_mode_t         mode;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] proj_a;
        logic signed [31:0] proj_b;
        logic signed [31:0] centre_depth;
    } cfg_t;

    // request as it leaves the front: either finished (u, v) or a pair to divide
    typedef struct packed {
        logic               is_div;
        logic               near;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        logic signed [32:0] d;
    } front_item_t;

    typedef struct packed {
        logic               near;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } map_item_t;

    typedef struct packed {
        logic [32:0] r;
        logic [31:0] q;
    } div_lane_t;

    typedef struct packed {
        logic               is_div;
        logic               near;
        logic               neg_x;
        logic               neg_y;
        logic               ovf_x;
        logic               ovf_y;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic [32:0]        dm;
    } div_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] val);
        logic signed [31:0] res;
        if (val > 64'sd2147483647)
            res = 32'sh7FFF_FFFF;
        else if (val < -64'sd2147483648)
            res = 32'sh8000_0000;
        else
            res = val[31:0];
        return res;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] val);
        logic signed [15:0] res;
        if (val > 64'sd32767)
            res = 16'sh7FFF;
        else if (val < -64'sd32768)
            res = 16'sh8000;
        else
            res = val[15:0];
        return res;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] val);
        logic [63:0] res;
        if (val[63])
            res = ~val + 64'd1;
        else
            res = val;
        return res;
    endfunction

    // one restoring division step
    function automatic div_lane_t div_step(input div_lane_t l, input logic [32:0] dm);
        div_lane_t   res;
        logic [33:0] t;
        t = {l.r, l.q[31]};
        if (t >= {1'b0, dm})
        begin
            res.r = 33'(t - {1'b0, dm});
            res.q = {l.q[30:0], 1'b1};
        end
        else
        begin
            res.r = t[32:0];
            res.q = {l.q[30:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// File: rtl/ppvm_front.sv
module ppvm_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic signed [31:0]   px,
    input  logic signed [31:0]   py,
    input  logic signed [31:0]   pz,
    input  ppvm_pkg::cfg_t       cfg,
    output logic                 push,
    output ppvm_pkg::front_item_t push_item,
    output logic [1:0]           occupancy
);

    localparam int NEAR_THRESH = ((1 << FRAC_BITS) + 999) / 1000;

    logic               a_valid_reg;
    logic signed [31:0] a_x_reg, a_y_reg, a_z_reg;

    logic               b_valid_reg;
    logic signed [31:0] b_x_reg, b_y_reg, b_z_reg;
    logic signed [63:0] b_xc_reg, b_yc_reg, b_az_reg, b_bz_reg;
    logic signed [32:0] b_d_reg, b_dx_reg, b_dy_reg;
    logic               b_near_reg;

    logic                  c_valid_reg;
    ppvm_pkg::front_item_t c_item_reg;

    logic signed [32:0]   d_next;
    logic [32:0]          ad;
    ppvm_pkg::front_item_t c_item_next;
    logic signed [63:0]   near_u, near_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg <= px;
            a_y_reg <= py;
            a_z_reg <= pz;
        end
    end

    always_comb
    begin
        d_next = 33'(cfg.centre_depth) - 33'(a_z_reg);
        ad     = d_next[32] ? 33'(-d_next) : 33'(d_next);
    end

    always_ff @(posedge clk)
    begin
        b_x_reg    <= a_x_reg;
        b_y_reg    <= a_y_reg;
        b_z_reg    <= a_z_reg;
        b_xc_reg   <= a_x_reg * cfg.centre_depth;
        b_yc_reg   <= a_y_reg * cfg.centre_depth;
        b_az_reg   <= cfg.proj_a * a_z_reg;
        b_bz_reg   <= cfg.proj_b * a_z_reg;
        b_d_reg    <= d_next;
        b_dx_reg   <= 33'(a_x_reg) - 33'(cfg.proj_a);
        b_dy_reg   <= 33'(a_y_reg) - 33'(cfg.proj_b);
        b_near_reg <= (ad < 33'(NEAR_THRESH));
    end

    always_comb
    begin
        near_u = 64'(b_dx_reg) * 64'(ppvm_pkg::NEAR_SCALE);
        near_v = 64'(b_dy_reg) * 64'(ppvm_pkg::NEAR_SCALE);
        c_item_next.is_div = 1'b0;
        c_item_next.near   = 1'b0;
        c_item_next.nx     = b_xc_reg - b_az_reg;
        c_item_next.ny     = b_yc_reg - b_bz_reg;
        c_item_next.d      = b_d_reg;
        case (cfg.mode)
            ppvm_pkg::MODE_SIDE:
            begin
                c_item_next.u = b_z_reg;
                c_item_next.v = b_y_reg;
            end
            ppvm_pkg::MODE_TOP:
            begin
                c_item_next.u = b_x_reg;
                c_item_next.v = b_z_reg;
            end
            ppvm_pkg::MODE_PERSP:
            begin
                c_item_next.u      = ppvm_pkg::sat32(near_u);
                c_item_next.v      = ppvm_pkg::sat32(near_v);
                c_item_next.near   = b_near_reg;
                c_item_next.is_div = !b_near_reg;
            end
            default:
            begin
                c_item_next.u = ppvm_pkg::sat32(64'(b_x_reg) + (b_az_reg >>> FRAC_BITS));
                c_item_next.v = ppvm_pkg::sat32(64'(b_y_reg) + (b_bz_reg >>> FRAC_BITS));
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        c_item_reg <= c_item_next;
    end

    assign push      = c_valid_reg;
    assign push_item = c_item_reg;
    assign occupancy = 2'(a_valid_reg) + 2'(b_valid_reg) + 2'(c_valid_reg);

endmodule

// File: rtl/ppvm_fifo.sv
module ppvm_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ppvm_pkg::front_item_t push_item,
    input  logic                  pop,
    output ppvm_pkg::front_item_t pop_item,
    output logic                  empty,
    output logic                  full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    ppvm_pkg::front_item_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        if (push && !pop)
            cnt_next = CW'(cnt_reg + 1'b1);
        else if (pop && !push)
            cnt_next = CW'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assign pop_item = mem_reg[rd_ptr_reg];
    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CW'(DEPTH));
    assign count    = cnt_reg;

endmodule

// File: rtl/ppvm_div.sv
module ppvm_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  ppvm_pkg::front_item_t in_item,
    output logic                  res_valid,
    output ppvm_pkg::map_item_t   res_item
);

    localparam int N = ppvm_pkg::DIV_STEPS;

    logic               p1_valid_reg;
    logic               p1_is_div_reg, p1_near_reg, p1_neg_x_reg, p1_neg_y_reg;
    logic signed [31:0] p1_u_reg, p1_v_reg;
    logic [63:0]        p1_mx_reg, p1_my_reg;
    logic [32:0]        p1_md_reg;

    logic               vld_reg [N+1];
    ppvm_pkg::div_ctl_t ctl_reg [N+1];
    ppvm_pkg::div_lane_t lx_reg [N+1];
    ppvm_pkg::div_lane_t ly_reg [N+1];

    logic                fin_valid_reg;
    ppvm_pkg::map_item_t fin_item_reg, fin_item_next;
    logic signed [32:0]  qx, qy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_is_div_reg <= in_item.is_div;
            p1_near_reg   <= in_item.near;
            p1_neg_x_reg  <= in_item.nx[63] ^ in_item.d[32];
            p1_neg_y_reg  <= in_item.ny[63] ^ in_item.d[32];
            p1_u_reg      <= in_item.u;
            p1_v_reg      <= in_item.v;
            p1_mx_reg     <= ppvm_pkg::mag64(in_item.nx);
            p1_my_reg     <= ppvm_pkg::mag64(in_item.ny);
            p1_md_reg     <= in_item.d[32] ? 33'(-in_item.d) : 33'(in_item.d);
        end
    end

    // quotient overflows 32 bits when the upper numerator half reaches the divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0].is_div <= p1_is_div_reg;
            ctl_reg[0].near   <= p1_near_reg;
            ctl_reg[0].neg_x  <= p1_neg_x_reg;
            ctl_reg[0].neg_y  <= p1_neg_y_reg;
            ctl_reg[0].ovf_x  <= ({1'b0, p1_mx_reg[63:32]} >= p1_md_reg);
            ctl_reg[0].ovf_y  <= ({1'b0, p1_my_reg[63:32]} >= p1_md_reg);
            ctl_reg[0].u      <= p1_u_reg;
            ctl_reg[0].v      <= p1_v_reg;
            ctl_reg[0].dm     <= p1_md_reg;
            lx_reg[0].r       <= {1'b0, p1_mx_reg[63:32]};
            lx_reg[0].q       <= p1_mx_reg[31:0];
            ly_reg[0].r       <= {1'b0, p1_my_reg[63:32]};
            ly_reg[0].q       <= p1_my_reg[31:0];
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
                lx_reg[k]  <= ppvm_pkg::div_step(lx_reg[k-1], ctl_reg[k-1].dm);
                ly_reg[k]  <= ppvm_pkg::div_step(ly_reg[k-1], ctl_reg[k-1].dm);
            end
        end
    end

    always_comb
    begin
        qx = ctl_reg[N].neg_x ? 33'(-{1'b0, lx_reg[N].q}) : 33'({1'b0, lx_reg[N].q});
        qy = ctl_reg[N].neg_y ? 33'(-{1'b0, ly_reg[N].q}) : 33'({1'b0, ly_reg[N].q});
        fin_item_next.near = ctl_reg[N].near;
        fin_item_next.u    = ctl_reg[N].u;
        fin_item_next.v    = ctl_reg[N].v;
        if (ctl_reg[N].is_div)
        begin
            if (ctl_reg[N].ovf_x)
                fin_item_next.u = ctl_reg[N].neg_x ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
                fin_item_next.u = ppvm_pkg::sat32(64'(qx));
            if (ctl_reg[N].ovf_y)
                fin_item_next.v = ctl_reg[N].neg_y ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
                fin_item_next.v = ppvm_pkg::sat32(64'(qy));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (en)
            fin_valid_reg <= vld_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fin_item_reg <= fin_item_next;
    end

    assign res_valid = fin_valid_reg;
    assign res_item  = fin_item_reg;

endmodule

// File: rtl/ppvm_map.sv
module ppvm_map #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ppvm_pkg::map_item_t in_item,
    input  ppvm_pkg::cfg_t      cfg,
    output logic                out_valid,
    output logic signed [15:0]  screen_x,
    output logic signed [15:0]  screen_y,
    output logic                near_flag
);

    localparam logic signed [63:0] FRAC_MASK = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    logic               m_valid_reg, m_near_reg;
    logic signed [63:0] m_px_reg, m_py_reg;

    logic               out_valid_reg, near_reg;
    logic signed [15:0] sx_reg, sy_reg;

    logic signed [63:0] wx, wy, ix, iy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg   <= in_valid;
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_near_reg <= in_item.near;
            m_px_reg   <= cfg.scale_x * in_item.u;
            m_py_reg   <= cfg.scale_y * in_item.v;
        end
    end

    // floor the product, add offset, then truncate toward zero
    always_comb
    begin
        wx = (m_px_reg >>> FRAC_BITS) + 64'(cfg.offset_x);
        wy = (m_py_reg >>> FRAC_BITS) + 64'(cfg.offset_y);
        ix = wx[63] ? ((wx + FRAC_MASK) >>> FRAC_BITS) : (wx >>> FRAC_BITS);
        iy = wy[63] ? ((wy + FRAC_MASK) >>> FRAC_BITS) : (wy >>> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg <= m_near_reg;
            sx_reg   <= ppvm_pkg::sat16(ix);
            sy_reg   <= ppvm_pkg::sat16(iy);
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;
    assign near_flag = near_reg;

endmodule

// File: rtl/point_projection_viewport_map_core.sv
// Point projection and window-to-viewport mapping.
// Input channel: one request per point (px, py, pz, signed fixed point),
// taken when in_valid is high and in_stall is low.
// Output channel: screen_x, screen_y and near_flag, taken when out_valid is
// high and out_stall is low. Exactly one result per request, in order.
// Configuration: cfg_we writes cfg_data to register cfg_index; write only
// while no request is in flight.
// The back end holds the 32-step pipelined restoring divider.
// Throughput: one request per cycle while in_stall and out_stall are low.
// The front end (three stages) never stalls; in_stall rises when the queue
// plus front stages hold FIFO_DEPTH requests. While out_stall holds a
// result, the back end freezes and the queue keeps taking requests until
// full.
// Reset clears all valid bits and pointers and loads the register defaults:
// perspective off (oblique), unit scales, zero offsets and projection terms.
module point_projection_viewport_map_core #(
    parameter int FRAC_BITS  = 16,
    parameter int FIFO_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic               near_flag,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int CW = $clog2(FIFO_DEPTH+1);
    localparam logic signed [31:0] UNIT = 32'(64'sd1 <<< FRAC_BITS);

    ppvm_pkg::cfg_t cfg_reg;

    logic                  accept;
    logic                  push, pop, empty, full;
    ppvm_pkg::front_item_t push_item, pop_item;
    logic [1:0]            front_occ;
    logic [CW-1:0]         fifo_cnt;
    logic [CW:0]           inflight;
    logic                  en;
    logic                  div_valid;
    ppvm_pkg::map_item_t   div_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= ppvm_pkg::MODE_OBLIQUE;
            cfg_reg.scale_x      <= UNIT;
            cfg_reg.scale_y      <= UNIT;
            cfg_reg.offset_x     <= '0;
            cfg_reg.offset_y     <= '0;
            cfg_reg.proj_a       <= '0;
            cfg_reg.proj_b       <= '0;
            cfg_reg.centre_depth <= '0;
        end
        else if (cfg_we)
        begin
            case (ppvm_pkg::cfg_reg_t'(cfg_index))
                ppvm_pkg::REG_VIEW_MODE:    cfg_reg.mode <= ppvm_pkg::view_mode_t'(cfg_data[1:0]);
                ppvm_pkg::REG_SCALE_X:      cfg_reg.scale_x      <= cfg_data;
                ppvm_pkg::REG_SCALE_Y:      cfg_reg.scale_y      <= cfg_data;
                ppvm_pkg::REG_OFFSET_X:     cfg_reg.offset_x     <= cfg_data;
                ppvm_pkg::REG_OFFSET_Y:     cfg_reg.offset_y     <= cfg_data;
                ppvm_pkg::REG_PROJ_A:       cfg_reg.proj_a       <= cfg_data;
                ppvm_pkg::REG_PROJ_B:       cfg_reg.proj_b       <= cfg_data;
                ppvm_pkg::REG_CENTRE_DEPTH: cfg_reg.centre_depth <= cfg_data;
                default: ;
            endcase
        end
    end

    assign inflight = (CW+1)'(fifo_cnt) + (CW+1)'(front_occ);
    assign in_stall = (inflight >= (CW+1)'(FIFO_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign en       = !out_valid || !out_stall;
    assign pop      = en && !empty;

    ppvm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .px        (px),
        .py        (py),
        .pz        (pz),
        .cfg       (cfg_reg),
        .push      (push),
        .push_item (push_item),
        .occupancy (front_occ)
    );

    ppvm_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty),
        .full      (full),
        .count     (fifo_cnt)
    );

    ppvm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pop),
        .in_item   (pop_item),
        .res_valid (div_valid),
        .res_item  (div_item)
    );

    ppvm_map #(.FRAC_BITS(FRAC_BITS)) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_item   (div_item),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .near_flag (near_flag)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        inflight <= (CW+1)'(FIFO_DEPTH))
        else $error("more requests in flight than queue slots");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

// File: tb/sv/point_projection_viewport_map_core_tb.sv
module point_projection_viewport_map_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam longint NEAR_MIN = ((64'sd1 << FRAC) + 999) / 1000;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               near;
    } screen_pt_t;

    class projection_scoreboard;
        ppvm_pkg::view_mode_t mode;
        logic signed [31:0]   sc_x, sc_y, off_x, off_y, pa, pb, cz;
        screen_pt_t           screen_q[$];
        int                   errors;

        function new();
            mode   = ppvm_pkg::MODE_OBLIQUE;
            sc_x   = 32'sd65536;
            sc_y   = 32'sd65536;
            off_x  = 0;
            off_y  = 0;
            pa     = 0;
            pb     = 0;
            cz     = 0;
            errors = 0;
        endfunction

        function void set_reg(ppvm_pkg::cfg_reg_t idx, logic [31:0] val);
            case (idx)
                ppvm_pkg::REG_VIEW_MODE:    mode = ppvm_pkg::view_mode_t'(val[1:0]);
                ppvm_pkg::REG_SCALE_X:      sc_x = val;
                ppvm_pkg::REG_SCALE_Y:      sc_y = val;
                ppvm_pkg::REG_OFFSET_X:     off_x = val;
                ppvm_pkg::REG_OFFSET_Y:     off_y = val;
                ppvm_pkg::REG_PROJ_A:       pa = val;
                ppvm_pkg::REG_PROJ_B:       pb = val;
                ppvm_pkg::REG_CENTRE_DEPTH: cz = val;
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function logic signed [15:0] to_screen(longint p, longint s, longint o);
            longint v;
            longint i;
            v = ((s * p) >>> FRAC) + o;
            i = (v >= 0) ? (v >>> FRAC) : -((-v) >>> FRAC);
            if (i > 32767)
                i = 32767;
            else if (i < -32768)
                i = -32768;
            return i[15:0];
        endfunction

        function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
            longint     lx, ly, lz, lc, la, lb, d, ad, u, v;
            screen_pt_t r;
            lx = x; ly = y; lz = z;
            lc = cz; la = pa; lb = pb;
            r.near = 1'b0;
            case (mode)
                ppvm_pkg::MODE_SIDE:
                begin
                    u = lz;
                    v = ly;
                end
                ppvm_pkg::MODE_TOP:
                begin
                    u = lx;
                    v = lz;
                end
                ppvm_pkg::MODE_PERSP:
                begin
                    d  = lc - lz;
                    ad = (d < 0) ? -d : d;
                    if (ad < NEAR_MIN)
                    begin
                        u = clamp32((lx - la) * 100000);
                        v = clamp32((ly - lb) * 100000);
                        r.near = 1'b1;
                    end
                    else
                    begin
                        u = clamp32((lx * lc - la * lz) / d);
                        v = clamp32((ly * lc - lb * lz) / d);
                    end
                end
                default:
                begin
                    u = clamp32(lx + ((lz * la) >>> FRAC));
                    v = clamp32(ly + ((lz * lb) >>> FRAC));
                end
            endcase
            r.sx = to_screen(u, longint'(sc_x), longint'(off_x));
            r.sy = to_screen(v, longint'(sc_y), longint'(off_y));
            screen_q.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(logic signed [15:0] sx, logic signed [15:0] sy,
                          logic near);
            screen_pt_t e;
            if (screen_q.size() == 0)
            begin
                report_mismatch("unexpected result, screen_x", sx, 0);
                return;
            end
            e = screen_q.pop_front();
            if (sx !== e.sx)
                report_mismatch("screen_x", sx, e.sx);
            if (sy !== e.sy)
                report_mismatch("screen_y", sy, e.sy);
            if (near !== e.near)
                report_mismatch("near_flag", near, e.near);
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] px = '0, py = '0, pz = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] screen_x, screen_y;
    logic               near_flag;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    projection_scoreboard sb = new();
    int  cycles = 0;
    bit  quiet = 1'b0;
    int  stall_left = 0;

    point_projection_viewport_map_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .px(px), .py(py), .pz(pz),
        .out_valid(out_valid), .out_stall(out_stall),
        .screen_x(screen_x), .screen_y(screen_y), .near_flag(near_flag),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(screen_x, screen_y, near_flag);
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (quiet || !rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        in_valid <= 1'b1;
        px <= x;
        py <= y;
        pz <= z;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_point(x, y, z);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.screen_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_regs(logic [31:0] vals[8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(ppvm_pkg::cfg_reg_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< FRAC;
            3: return 32'($signed($urandom_range(0, 400)) - 200);
            default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
        endcase
    endfunction

    initial
    begin
        logic [31:0]        regs[8];
        logic signed [31:0] z;
        logic signed [31:0] ext[4];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, field extremes
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send_point(ext[i], ext[j], ext[(i + j) % 4]);
        send_point(32'sd5 <<< FRAC, -(32'sd7 <<< FRAC), 32'sd3 <<< FRAC);
        send_point(32'sd32768 <<< FRAC, -(32'sd32769 <<< FRAC), 0);
        drain();

        // perspective near threshold edges
        regs = '{ppvm_pkg::MODE_PERSP, 32'sd65536, 32'sd65536, 0, 0,
                 32'sd1 <<< FRAC, -(32'sd2 <<< FRAC), 32'sd10 <<< FRAC};
        write_regs(regs);
        foreach (ext[i])
        begin
            send_point(ext[i], 32'sd3 <<< FRAC, (32'sd10 <<< FRAC) - 65);
            send_point(ext[i], -(32'sd3 <<< FRAC), (32'sd10 <<< FRAC) + 66);
        end
        send_point(32'sd4 <<< FRAC, 32'sd4 <<< FRAC, 32'sd10 <<< FRAC);
        send_point(32'sd4 <<< FRAC, 32'sd4 <<< FRAC, (32'sd10 <<< FRAC) - 66);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            quiet = (ph >= 10);
            regs[ppvm_pkg::REG_VIEW_MODE] = ph % 4;
            if (ph >= 4 && ph < 8)
            begin
                regs[ppvm_pkg::REG_SCALE_X]      = (ph % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
                regs[ppvm_pkg::REG_SCALE_Y]      = (ph % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                regs[ppvm_pkg::REG_OFFSET_X]     = ext[ph % 4];
                regs[ppvm_pkg::REG_OFFSET_Y]     = ext[(ph + 1) % 4];
                regs[ppvm_pkg::REG_PROJ_A]       = ext[(ph + 2) % 4];
                regs[ppvm_pkg::REG_PROJ_B]       = ext[(ph + 3) % 4];
                regs[ppvm_pkg::REG_CENTRE_DEPTH] = ext[ph % 4];
            end
            else
            begin
                regs[ppvm_pkg::REG_SCALE_X]      = rand_scale();
                regs[ppvm_pkg::REG_SCALE_Y]      = rand_scale();
                regs[ppvm_pkg::REG_OFFSET_X]     = rand_coord();
                regs[ppvm_pkg::REG_OFFSET_Y]     = rand_coord();
                regs[ppvm_pkg::REG_PROJ_A]       = rand_coord();
                regs[ppvm_pkg::REG_PROJ_B]       = rand_coord();
                regs[ppvm_pkg::REG_CENTRE_DEPTH] = rand_coord();
            end
            write_regs(regs);
            for (int k = 0; k < 65; k++)
            begin
                z = rand_coord();
                if (ph % 4 == ppvm_pkg::MODE_PERSP && $urandom_range(0, 2) == 0)
                    z = $signed(regs[ppvm_pkg::REG_CENTRE_DEPTH]) +
                        32'($signed($urandom_range(0, 140)) - 70);
                send_point(rand_coord(), rand_coord(), z);
                if (ph == 2 && k == 30)
                begin
                    in_valid <= 1'b0;
                    while (sb.screen_q.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: sim.f
rtl/ppvm_pkg.sv
rtl/ppvm_front.sv
rtl/ppvm_fifo.sv
rtl/ppvm_div.sv
rtl/ppvm_map.sv
rtl/point_projection_viewport_map_core.sv
tb/sv/point_projection_viewport_map_core_tb.sv
